// ===== sv/base32_token_decoder_defines.svh =====
// assertion macros shared by the base32 token decoder rtl
`ifndef BASE32_TOKEN_DECODER_DEFINES_SVH
`define BASE32_TOKEN_DECODER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define B32TD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define B32TD_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

// ===== sv/b32td_pkg.sv =====
// types, constants and helpers for the base32 token decoder
package b32td_pkg;

    // payload counter width and output total width
    localparam int COUNT_BITS = 10;
    localparam int TOTAL_W    = 10;
    localparam int CMP_W      = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_PSK_DIGIT = 2'd0;
    localparam logic [1:0] CFG_MIN_PSK   = 2'd1;
    localparam logic [1:0] CFG_MIN_OTHER = 2'd2;

    // result item kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // character codes
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_CASE    = 8'h20;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_Z       = 8'h5A;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] SYM_DIGIT_BASE = 8'd26;

    // parse phases
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_S      = 3'd1,
        PH_SP     = 3'd2,
        PH_PREFIX = 3'd3,
        PH_DATA   = 3'd4,
        PH_EQ     = 3'd5,
        PH_WS     = 3'd6
    } phase_t;

    // final status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NOVER  = 3'd1,
        ST_BADCHR = 3'd2,
        ST_BADLEN = 3'd3,
        ST_SHORT  = 3'd4
    } status_t;

    // per-token parse state
    typedef struct packed {
        phase_t                  phase;
        logic [6:0]              bit_buf;
        logic [2:0]              bit_fill;
        logic [2:0]              mod8;
        logic                    version;
        logic [COUNT_BITS-1:0]   count;
        status_t                 err;
    } tok_state_t;

    localparam tok_state_t TOK_IDLE = '{
        phase:    PH_LEAD,
        bit_buf:  7'd0,
        bit_fill: 3'd0,
        mod8:     3'd0,
        version:  1'b0,
        count:    '0,
        err:      ST_OK
    };

    // configuration register set
    typedef struct packed {
        logic         psk_digit;
        logic [9:0]   min_psk;
        logic [9:0]   min_other;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic                item_kind;
        logic [7:0]          data_byte;
        status_t             status_code;
        logic                version_digit;
        logic [TOTAL_W-1:0]  byte_total;
        logic                end_of_run;
    } res_t;

    // payload count clipped to the output total width
    function automatic logic [TOTAL_W-1:0] sat_total(input logic [COUNT_BITS-1:0] cnt);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(cnt);
        if (wide > CMP_W'({TOTAL_W{1'b1}})) begin
            return {TOTAL_W{1'b1}};
        end
        return wide[TOTAL_W-1:0];
    endfunction

endpackage

// ===== sv/base32_token_decoder.sv =====
// top level of the streaming base32 pairing token decoder
//
//   port group   direction   transfer when        carries
//   cfg_*        in          cfg_wr_en            register index and value
//   s_*          in          s_valid && s_ready   one character and last flag
//   m_*          out         m_valid && m_ready   payload byte or final status
//
// one character per cycle while the result queue has room: a character is held
// in an input register, decoded from there and its results land in a four-entry
// result queue. a last character that also completes a byte gives two results;
// the queue drains one per cycle while m_ready is high, so input stalls only when
// it holds more than two. a result passes the input register, then a queue entry.
// reset is synchronous; no clearing pass, the block is ready right after it.
`include "base32_token_decoder_defines.svh"

module base32_token_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_item_kind,
    output logic [7:0]  m_data_byte,
    output logic [2:0]  m_status_code,
    output logic        m_version_digit,
    output logic [9:0]  m_byte_total,
    output logic        m_end_of_run
);

    b32td_pkg::cfg_t       cfg_reg, cfg_next;
    b32td_pkg::tok_state_t tok_reg, tok_next;
    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            char_reg;
    logic                  last_reg;
    logic                  advance;
    logic                  room;
    logic                  s_xfer;
    logic [1:0]            step_cnt;
    logic [1:0]            push_cnt;
    b32td_pkg::res_t       res_a, res_b, head;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                b32td_pkg::CFG_PSK_DIGIT: cfg_next.psk_digit = cfg_data[0];
                b32td_pkg::CFG_MIN_PSK:   cfg_next.min_psk   = cfg_data;
                b32td_pkg::CFG_MIN_OTHER: cfg_next.min_other = cfg_data;
                default:                  cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.psk_digit <= 1'b1;
            cfg_reg.min_psk   <= 10'd64;
            cfg_reg.min_other <= 10'd24;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // input register and its handshake
    assign advance       = in_valid_reg && room;
    assign s_ready       = !in_valid_reg || advance;
    assign s_xfer        = s_valid && s_ready;
    assign in_valid_next = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            char_reg <= s_char_code;
            last_reg <= s_last_char;
        end
    end

    // decode step
    b32td_step u_step (
        .tok       (tok_reg),
        .cfg       (cfg_reg),
        .char_code (char_reg),
        .last_char (last_reg),
        .tok_next  (tok_next),
        .res_a     (res_a),
        .res_b     (res_b),
        .push_cnt  (step_cnt)
    );

    // token state advances once per decoded character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= b32td_pkg::TOK_IDLE;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign push_cnt = advance ? step_cnt : 2'd0;

    // result queue
    b32td_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .res_a    (res_a),
        .res_b    (res_b),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    // output fields
    assign m_item_kind     = head.item_kind;
    assign m_data_byte     = head.data_byte;
    assign m_status_code   = head.status_code;
    assign m_version_digit = head.version_digit;
    assign m_byte_total    = head.byte_total;
    assign m_end_of_run    = head.end_of_run;

    `B32TD_ASSERT(a_tok_clear_after_last, !(advance && last_reg) || (tok_next == b32td_pkg::TOK_IDLE), "token state not cleared on last character")
    `B32TD_NEVER(a_count_before_data, (tok_reg.phase < b32td_pkg::PH_DATA) && (tok_reg.count != '0), "payload counted before version")
    `B32TD_NEVER(a_stall_ready, in_valid_reg && !room && s_ready, "input ready while held character stalls")

endmodule

// ===== sv/b32td_step.sv =====
// per-character parse, base32 decode and final status logic
module b32td_step (
    input  b32td_pkg::tok_state_t tok,
    input  b32td_pkg::cfg_t       cfg,
    input  logic [7:0]            char_code,
    input  logic                  last_char,
    output b32td_pkg::tok_state_t tok_next,
    output b32td_pkg::res_t       res_a,
    output b32td_pkg::res_t       res_b,
    output logic [1:0]            push_cnt
);

    logic [7:0]  ch;
    logic [7:0]  ch9;
    logic        ws;
    logic        sym_ok;
    logic [4:0]  sym_v;
    logic [11:0] acc;
    logic [3:0]  fill_sum;
    logic [2:0]  fill_new;
    logic [11:0] acc_shift;
    logic [11:0] keep_mask;
    logic        emit_byte;
    logic [7:0]  byte_val;
    logic        digit;
    b32td_pkg::tok_state_t upd;
    b32td_pkg::status_t    st;
    logic        data_phase;
    logic        ver;
    logic [9:0]  need;
    b32td_pkg::res_t byte_item;
    b32td_pkg::res_t stat_item;

    // case fold and character classes
    always_comb begin
        ch = char_code;
        if (char_code >= b32td_pkg::CH_LOWER_A && char_code <= b32td_pkg::CH_LOWER_Z) begin
            ch = char_code - b32td_pkg::CH_CASE;
        end
        ws = (ch == b32td_pkg::CH_SPACE) ||
             (ch >= b32td_pkg::CH_TAB && ch <= b32td_pkg::CH_CR);
        digit = (ch == b32td_pkg::CH_ZERO) || (ch == b32td_pkg::CH_ONE);
    end

    // base32 symbol value, 9 read as 2
    always_comb begin
        ch9    = (ch == b32td_pkg::CH_NINE) ? b32td_pkg::CH_TWO : ch;
        sym_ok = 1'b0;
        sym_v  = 5'd0;
        if (ch9 >= b32td_pkg::CH_A && ch9 <= b32td_pkg::CH_Z) begin
            sym_ok = 1'b1;
            sym_v  = 5'(ch9 - b32td_pkg::CH_A);
        end else if (ch9 >= b32td_pkg::CH_TWO && ch9 <= b32td_pkg::CH_SEVEN) begin
            sym_ok = 1'b1;
            sym_v  = 5'(ch9 - b32td_pkg::CH_TWO + b32td_pkg::SYM_DIGIT_BASE);
        end
    end

    // bit accumulator: leftover bits stay below the new fill level
    always_comb begin
        acc       = {tok.bit_buf, sym_v};
        fill_sum  = {1'b0, tok.bit_fill} + 4'd5;
        fill_new  = fill_sum[2:0];
        acc_shift = acc >> fill_new;
        byte_val  = acc_shift[7:0];
        keep_mask = (12'd1 << fill_new) - 12'd1;
    end

    // phase transitions
    always_comb begin
        upd       = tok;
        emit_byte = 1'b0;
        if (tok.err == b32td_pkg::ST_OK) begin
            unique case (tok.phase)
                b32td_pkg::PH_LEAD: begin
                    if (!ws) begin
                        if (ch == b32td_pkg::CH_S) begin
                            upd.phase = b32td_pkg::PH_S;
                        end else if (digit) begin
                            upd.version = ch[0];
                            upd.phase   = b32td_pkg::PH_DATA;
                        end else begin
                            upd.err = b32td_pkg::ST_NOVER;
                        end
                    end
                end
                b32td_pkg::PH_S: begin
                    if (ch == b32td_pkg::CH_P) upd.phase = b32td_pkg::PH_SP;
                    else upd.err = b32td_pkg::ST_NOVER;
                end
                b32td_pkg::PH_SP: begin
                    if (ch == b32td_pkg::CH_COLON) upd.phase = b32td_pkg::PH_PREFIX;
                    else upd.err = b32td_pkg::ST_NOVER;
                end
                b32td_pkg::PH_PREFIX: begin
                    if (digit) begin
                        upd.version = ch[0];
                        upd.phase   = b32td_pkg::PH_DATA;
                    end else begin
                        upd.err = b32td_pkg::ST_NOVER;
                    end
                end
                b32td_pkg::PH_DATA: begin
                    if (ws) begin
                        upd.phase = b32td_pkg::PH_WS;
                    end else if (ch == b32td_pkg::CH_EQ) begin
                        upd.phase = b32td_pkg::PH_EQ;
                    end else if (!sym_ok) begin
                        upd.err = b32td_pkg::ST_BADCHR;
                    end else begin
                        upd.mod8     = tok.mod8 + 3'd1;
                        upd.bit_buf  = 7'(acc & keep_mask);
                        upd.bit_fill = fill_new;
                        emit_byte    = fill_sum[3];
                        if (fill_sum[3] && tok.count != {b32td_pkg::COUNT_BITS{1'b1}}) begin
                            upd.count = tok.count + 1'b1;
                        end
                    end
                end
                b32td_pkg::PH_EQ: begin
                    if (ws) upd.phase = b32td_pkg::PH_WS;
                    else if (ch != b32td_pkg::CH_EQ) upd.err = b32td_pkg::ST_BADCHR;
                end
                default: begin
                    if (!ws) upd.err = b32td_pkg::ST_BADCHR;
                end
            endcase
        end
    end

    // final status from the updated state
    always_comb begin
        data_phase = (upd.phase >= b32td_pkg::PH_DATA);
        ver        = data_phase ? upd.version : 1'b0;
        need       = (ver == cfg.psk_digit) ? cfg.min_psk : cfg.min_other;
        st         = upd.err;
        if (st == b32td_pkg::ST_OK && !data_phase) begin
            st = b32td_pkg::ST_NOVER;
        end
        if (st == b32td_pkg::ST_OK &&
            (upd.mod8 == 3'd1 || upd.mod8 == 3'd3 || upd.mod8 == 3'd6)) begin
            st = b32td_pkg::ST_BADLEN;
        end
        if (st == b32td_pkg::ST_OK &&
            b32td_pkg::CMP_W'(upd.count) < b32td_pkg::CMP_W'(need)) begin
            st = b32td_pkg::ST_SHORT;
        end
    end

    // result items, byte first then status
    always_comb begin
        byte_item               = '0;
        byte_item.item_kind     = b32td_pkg::KIND_BYTE;
        byte_item.data_byte     = byte_val;
        byte_item.status_code   = b32td_pkg::ST_OK;

        stat_item               = '0;
        stat_item.item_kind     = b32td_pkg::KIND_STATUS;
        stat_item.status_code   = st;
        stat_item.version_digit = ver;
        stat_item.byte_total    = b32td_pkg::sat_total(upd.count);
        stat_item.end_of_run    = 1'b1;

        res_a    = emit_byte ? byte_item : stat_item;
        res_b    = stat_item;
        push_cnt = {1'b0, emit_byte} + {1'b0, last_char};
        tok_next = last_char ? b32td_pkg::TOK_IDLE : upd;
    end

endmodule

// ===== sv/b32td_result_fifo.sv =====
// small result queue taking up to two items per cycle, draining one while m_ready is high
`include "base32_token_decoder_defines.svh"

module b32td_result_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      push_cnt,
    input  b32td_pkg::res_t res_a,
    input  b32td_pkg::res_t res_b,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output b32td_pkg::res_t head
);

    b32td_pkg::res_t entry_reg [b32td_pkg::FIFO_DEPTH];
    logic [b32td_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [b32td_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [b32td_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [b32td_pkg::FIFO_PTR_W-1:0] wr_ptr_inc;
    logic pop;

    // handshake and occupancy
    assign m_valid    = (count_reg != '0);
    assign pop        = m_valid && m_ready;
    assign room       = (count_reg <= b32td_pkg::FIFO_CNT_W'(b32td_pkg::FIFO_DEPTH - 2));
    assign head       = entry_reg[rd_ptr_reg];
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + b32td_pkg::FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + b32td_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + b32td_pkg::FIFO_CNT_W'(push_cnt)
                    - b32td_pkg::FIFO_CNT_W'(pop);
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= res_a;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_ptr_inc] <= res_b;
        end
    end

    `B32TD_NEVER(a_fifo_overflow, count_reg > b32td_pkg::FIFO_CNT_W'(b32td_pkg::FIFO_DEPTH), "result queue overflow")
    `B32TD_ASSERT(a_fifo_empty_ptrs, (count_reg != '0) || (wr_ptr_reg == rd_ptr_reg), "empty queue with split pointers")
    `B32TD_NEVER(a_fifo_push_no_room, (push_cnt != 2'd0) && !room, "push into queue without room")

endmodule

// ===== sim/tb_base32_token_decoder.sv =====
// testbench for the streaming base32 pairing token decoder
`timescale 1ns / 100ps

module tb_base32_token_decoder;
    import b32td_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_item_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    // clock, reset and block inputs, all known from time zero
    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [1:0] cfg_index   = CFG_PSK_DIGIT;
    logic [9:0] cfg_data    = 10'd0;
    logic       s_valid     = 1'b0;
    logic [7:0] s_char_code = 8'd0;
    logic       s_last_char = 1'b0;
    logic       m_ready     = 1'b0;

    logic       s_ready;
    logic       m_valid;
    logic       m_item_kind;
    logic [7:0] m_data_byte;
    logic [2:0] m_status_code;
    logic       m_version_digit;
    logic [9:0] m_byte_total;
    logic       m_end_of_run;

    // characters waiting to be sent and results waiting to arrive
    char_item_t chars_pending[$];
    res_t       results_due[$];

    int queued_chars = 0;
    int chars_sent   = 0;
    int mismatches   = 0;
    int cycles       = 0;
    bit chr_taken    = 1'b0;

    // sender pacing
    int burst_left = 0;
    int gap_left   = 0;

    // receiver pacing
    rx_mode_t   rx_mode   = RX_FREE;
    int         mode_left = 0;
    logic [7:0] rx_pat    = 8'b1011_0110;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // register copies used for prediction
    logic       cfg_psk_digit = 1'b1;
    logic [9:0] cfg_min_psk   = 10'd64;
    logic [9:0] cfg_min_other = 10'd24;

    // per-token decode state used for prediction
    phase_t                tok_phase = PH_LEAD;
    logic [6:0]            tok_buf   = '0;
    logic [2:0]            tok_fill  = '0;
    logic [2:0]            tok_mod8  = '0;
    logic                  tok_ver   = 1'b0;
    logic [COUNT_BITS-1:0] tok_count = '0;
    status_t               tok_err   = ST_OK;

    base32_token_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_last_char     (s_last_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_data_byte     (m_data_byte),
        .m_status_code   (m_status_code),
        .m_version_digit (m_version_digit),
        .m_byte_total    (m_byte_total),
        .m_end_of_run    (m_end_of_run)
    );

    always #10 aclk = ~aclk;

    // symbol value of a folded character, -1 when it is not base32
    function automatic int sym_of_char(input logic [7:0] c);
        logic [7:0] d;
        d = (c == CH_NINE) ? CH_TWO : c;
        if (d >= CH_A && d <= CH_Z) return int'(d - CH_A);
        if (d >= CH_TWO && d <= CH_SEVEN) return int'(d - CH_TWO) + int'(SYM_DIGIT_BASE);
        return -1;
    endfunction

    // advance the token decode by one character and queue its results
    task automatic decode_char(input logic [7:0] code, input logic last);
        logic [7:0] c;
        logic       ws;
        int         sym;
        int         acc;
        int         fill;
        status_t    st;
        logic       ver;
        logic [9:0] need;
        res_t       r;
        c = code;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CH_CASE;
        ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        if (tok_err == ST_OK) begin
            case (tok_phase)
                PH_LEAD: begin
                    if (ws) begin
                    end else if (c == CH_S) begin
                        tok_phase = PH_S;
                    end else if (c == CH_ZERO || c == CH_ONE) begin
                        tok_ver   = c[0];
                        tok_phase = PH_DATA;
                    end else begin
                        tok_err = ST_NOVER;
                    end
                end
                PH_S: begin
                    if (c == CH_P) tok_phase = PH_SP;
                    else tok_err = ST_NOVER;
                end
                PH_SP: begin
                    if (c == CH_COLON) tok_phase = PH_PREFIX;
                    else tok_err = ST_NOVER;
                end
                PH_PREFIX: begin
                    if (c == CH_ZERO || c == CH_ONE) begin
                        tok_ver   = c[0];
                        tok_phase = PH_DATA;
                    end else begin
                        tok_err = ST_NOVER;
                    end
                end
                PH_DATA: begin
                    sym = sym_of_char(c);
                    if (ws) begin
                        tok_phase = PH_WS;
                    end else if (c == CH_EQ) begin
                        tok_phase = PH_EQ;
                    end else if (sym < 0) begin
                        tok_err = ST_BADCHR;
                    end else begin
                        // shift in five bits, emit a byte once eight are held
                        tok_mod8 = tok_mod8 + 3'd1;
                        acc  = (int'(tok_buf) << 5) | sym;
                        fill = int'(tok_fill) + 5;
                        if (fill >= 8) begin
                            fill -= 8;
                            r             = '0;
                            r.item_kind   = KIND_BYTE;
                            r.data_byte   = 8'(acc >> fill);
                            r.status_code = ST_OK;
                            results_due = {results_due, r};
                            if (tok_count != '1) tok_count = tok_count + 1'b1;
                        end
                        tok_buf  = 7'(acc & ((1 << fill) - 1));
                        tok_fill = 3'(fill);
                    end
                end
                PH_EQ: begin
                    if (ws) tok_phase = PH_WS;
                    else if (c != CH_EQ) tok_err = ST_BADCHR;
                end
                default: begin
                    if (!ws) tok_err = ST_BADCHR;
                end
            endcase
        end

        // final status: sticky error, then missing version, length, minimum
        if (last) begin
            st  = tok_err;
            ver = (tok_phase >= PH_DATA) ? tok_ver : 1'b0;
            need = (ver == cfg_psk_digit) ? cfg_min_psk : cfg_min_other;
            if (st == ST_OK && tok_phase < PH_DATA) st = ST_NOVER;
            if (st == ST_OK && (tok_mod8 == 3'd1 || tok_mod8 == 3'd3 || tok_mod8 == 3'd6))
                st = ST_BADLEN;
            if (st == ST_OK && tok_count < need) st = ST_SHORT;
            r               = '0;
            r.item_kind     = KIND_STATUS;
            r.status_code   = st;
            r.version_digit = ver;
            r.byte_total    = sat_total(tok_count);
            r.end_of_run    = 1'b1;
            results_due = {results_due, r};
            tok_phase = PH_LEAD;
            tok_buf   = '0;
            tok_fill  = '0;
            tok_mod8  = '0;
            tok_ver   = 1'b0;
            tok_count = '0;
            tok_err   = ST_OK;
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // input transfers feed the prediction; result transfers are checked in order
    always @(posedge aclk) begin : monitor
        res_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else if (aresetn) begin
            if (s_valid && s_ready) begin
                chr_taken = 1'b1;
                chars_sent++;
                decode_char(s_char_code, s_last_char);
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", int'(m_item_kind), -1);
                end else begin
                    want = results_due.pop_front();
                    if (m_item_kind !== want.item_kind)
                        flag_mismatch("item_kind", m_item_kind, want.item_kind);
                    if (m_data_byte !== want.data_byte)
                        flag_mismatch("data_byte", m_data_byte, want.data_byte);
                    if (m_status_code !== want.status_code)
                        flag_mismatch("status_code", m_status_code, int'(want.status_code));
                    if (m_version_digit !== want.version_digit)
                        flag_mismatch("version_digit", m_version_digit, want.version_digit);
                    if (m_byte_total !== want.byte_total)
                        flag_mismatch("byte_total", m_byte_total, want.byte_total);
                    if (m_end_of_run !== want.end_of_run)
                        flag_mismatch("end_of_run", m_end_of_run, want.end_of_run);
                end
            end
        end
    end

    // sender: bursts of characters separated by random gaps
    always @(negedge aclk) begin : tx_drive
        char_item_t it;
        logic       nv;
        if (!s_valid || chr_taken) begin
            chr_taken = 1'b0;
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (aresetn && chars_pending.size() > 0) begin
                it = chars_pending.pop_front();
                s_char_code <= it.code;
                s_last_char <= it.last;
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 30);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                        8:          gap_left = $urandom_range(5, 15);
                        default:    gap_left = $urandom_range(16, 40);
                    endcase
                end
            end
            s_valid <= nv;
        end
    end

    // receiver: changing stall modes, and one long hold-off to back up the block
    always @(negedge aclk) begin : rx_pace
        logic rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && chars_sent >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rdy = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default: begin
                    rdy    = rx_pat[0];
                    rx_pat = {rx_pat[0], rx_pat[7:1]};
                end
            endcase
        end
        m_ready <= rdy;
    end

    task automatic push_chr(input logic [7:0] code, input logic last);
        char_item_t it;
        it.code = code;
        it.last = last;
        chars_pending = {chars_pending, it};
        queued_chars++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_chr(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (c >= CH_A && c <= CH_Z && $urandom_range(0, 2) == 0) return c + CH_CASE;
        return c;
    endfunction

    function automatic logic [7:0] ws_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? CH_SPACE : CH_TAB + 8'(k - 1);
    endfunction

    function automatic logic [7:0] data_char();
        int         v;
        logic [7:0] c;
        v = $urandom_range(0, 31);
        c = (v < 26) ? CH_A + 8'(v) : CH_TWO + 8'(v - 26);
        if (c == CH_TWO && $urandom_range(0, 2) == 0) c = CH_NINE;
        return mix_case(c);
    endfunction

    // one token, mostly well formed around the byte target, sometimes broken
    task automatic queue_token(input int target);
        logic [7:0] tok[$];
        int         need;
        int         ndata;
        int         keep;
        need = (target * 8 + 4) / 5;
        repeat ($urandom_range(0, 2)) tok = {tok, ws_char()};
        if ($urandom_range(0, 2) == 0) begin
            tok = {tok, mix_case(CH_S)};
            tok = {tok, mix_case(CH_P)};
            tok = {tok, CH_COLON};
        end
        tok = {tok, ($urandom_range(0, 1) ? CH_ONE : CH_ZERO)};
        ndata = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
              : $urandom_range(need > 6 ? need - 6 : 0, need + 10);
        repeat (ndata) tok = {tok, data_char()};
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) tok = {tok, CH_EQ};
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) tok = {tok, ws_char()};
        case ($urandom_range(0, 19))
            0, 1: tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom_range(0, 255));
            2: begin
                keep = $urandom_range(1, tok.size());
                while (tok.size() > keep) void'(tok.pop_back());
            end
            3: begin
                tok.delete();
                repeat ($urandom_range(1, 6)) tok = {tok, 8'($urandom_range(0, 255))};
            end
            4: begin
                tok = {tok, CH_EQ};
                tok = {tok, data_char()};
            end
            5: begin
                tok = {tok, ws_char()};
                tok = {tok, ($urandom_range(0, 1) ? CH_EQ : data_char())};
            end
            default: ;
        endcase
        foreach (tok[i]) push_chr(tok[i], i == tok.size() - 1);
    endtask

    // idle once every character is taken and every result has come back
    task automatic wait_drained();
        do @(posedge aclk);
        while (chars_pending.size() != 0 || s_valid || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic psk, input logic [9:0] min_psk,
                                input logic [9:0] min_other);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PSK_DIGIT;
        cfg_data  <= {9'd0, psk};
        @(negedge aclk);
        cfg_index <= CFG_MIN_PSK;
        cfg_data  <= min_psk;
        @(negedge aclk);
        cfg_index <= CFG_MIN_OTHER;
        cfg_data  <= min_other;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_psk_digit = psk;
        cfg_min_psk   = min_psk;
        cfg_min_other = min_other;
    endtask

    // reset, directed tokens, then random tokens over several register settings
    initial begin : stimulus
        int         phase_end;
        int         tgt;
        logic       pd;
        logic [9:0] mp;
        logic [9:0] mo;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed cases under the reset register values
        push_chr(8'h00, 1'b1);
        push_text("S");
        push_text("sx");
        push_text("\t sp:0");
        push_text("1A");
        push_text("0a9=\n");
        push_text("1A=A");
        push_text("1 =");
        push_chr(CH_ZERO, 1'b0);
        push_chr(8'hFF, 1'b1);

        // zero minimums: most well-formed tokens pass
        wait_drained();
        write_config(1'b0, 10'd0, 10'd0);
        phase_end = queued_chars + 80;
        while (queued_chars < phase_end) queue_token(0);

        // maximum minimums: every well-formed token is too short
        wait_drained();
        write_config(1'b1, 10'd1023, 10'd1023);
        phase_end = queued_chars + 30;
        while (queued_chars < phase_end) queue_token(2);

        // version 0 is the psk kind and can never reach its minimum
        wait_drained();
        write_config(1'b0, 10'd1023, 10'd0);
        phase_end = queued_chars + 40;
        while (queued_chars < phase_end) queue_token(0);

        repeat (7) begin
            wait_drained();
            pd = 1'($urandom_range(0, 1));
            mp = 10'($urandom_range(0, 12));
            mo = 10'($urandom_range(0, 12));
            write_config(pd, mp, mo);
            tgt = (mp > mo) ? mp : mo;
            phase_end = queued_chars + 50;
            while (queued_chars < phase_end) queue_token(tgt);
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== base32_token_decoder.f =====
+incdir+sv
sv/b32td_pkg.sv
sv/b32td_step.sv
sv/b32td_result_fifo.sv
sv/base32_token_decoder.sv
sim/tb_base32_token_decoder.sv
